// File: hw/rtl/graph_segmentation_merge_unit_defines.svh
// Assertion macros for the graph segmentation merge unit
`ifndef GRAPH_SEGMENTATION_MERGE_UNIT_DEFINES_SVH
`define GRAPH_SEGMENTATION_MERGE_UNIT_DEFINES_SVH

// checked only while out of reset
`define GSM_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// checked at every edge, reset included
`define GSM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hw/rtl/gsm_pkg.sv
// Shared types, constants and helpers of the graph segmentation merge unit
package gsm_pkg;

  localparam int unsigned MaxVertices = 4096;
  localparam int unsigned VtxW        = $clog2(MaxVertices);
  localparam int unsigned SizeW       = VtxW + 1;
  localparam int unsigned WgtW        = 16;
  localparam int unsigned KW          = 20;
  localparam int unsigned ProdW       = WgtW + SizeW;

  localparam logic [KW-1:0] KReset = 20'd51200;

  localparam logic CmdEdge  = 1'b0;
  localparam logic CmdQuery = 1'b1;

  typedef struct packed {
    logic            command;
    logic [VtxW-1:0] vertex_a;
    logic [VtxW-1:0] vertex_b;
    logic [WgtW-1:0] edge_weight;
  } gsm_in_t;

  typedef struct packed {
    logic            joined;
    logic [VtxW-1:0] root_label;
  } gsm_out_t;

  typedef enum logic [3:0] {
    StClear,
    StIdle,
    StARd,
    StAChk,
    StBRd,
    StBChk,
    StEvalA,
    StEvalB,
    StDone
  } gsm_state_e;

  typedef struct packed {
    logic clr_wr;
    logic clr_step;
    logic load_item;
    logic step;
    logic sel_b;
    logic cap_a;
    logic cap_b;
    logic eval_a;
    logic eval_b;
    logic wr_merge;
    logic load_out;
  } gsm_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic is_root;
    logic is_query;
    logic merge_ok;
    logic out_free;
  } gsm_status_t;

  // w <= m + floor(k / s)  <=>  w <= m  or  (w - m) * s <= k
  function automatic logic within_limit(logic [WgtW-1:0] w, logic [WgtW-1:0] m,
                                        logic [SizeW-1:0] s, logic [KW-1:0] k);
    logic [WgtW-1:0]  diff;
    logic [SizeW-1:0] s_eff;
    logic [ProdW-1:0] prod;
    diff  = w - m;
    s_eff = (s == '0) ? SizeW'(1) : s;
    prod  = ProdW'(diff) * ProdW'(s_eff);
    return (w <= m) || (prod <= ProdW'(k));
  endfunction

endpackage

// File: hw/rtl/gsm_datapath.sv
// Datapath: union-find memories, root walk registers, merge test and output register
module gsm_datapath (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [gsm_pkg::KW-1:0] cfg_wdata_i,
  input  gsm_pkg::gsm_in_t      in_data_i,
  output gsm_pkg::gsm_out_t     out_data_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  input  gsm_pkg::gsm_cmd_t     cmd_i,
  output gsm_pkg::gsm_status_t  status_o
);

  localparam int unsigned VtxW  = gsm_pkg::VtxW;
  localparam int unsigned SizeW = gsm_pkg::SizeW;
  localparam int unsigned WgtW  = gsm_pkg::WgtW;

  logic [VtxW-1:0]  par_mem  [gsm_pkg::MaxVertices];
  logic [SizeW-1:0] size_mem [gsm_pkg::MaxVertices];
  logic [WgtW-1:0]  max_mem  [gsm_pkg::MaxVertices];

  logic [VtxW-1:0]  par_rd_q;
  logic [SizeW-1:0] sz_rd_q;
  logic [WgtW-1:0]  mx_rd_q;

  gsm_pkg::gsm_in_t  item_q;
  gsm_pkg::gsm_out_t out_q;
  logic              out_valid_q;
  logic [VtxW-1:0]   cur_q, ra_q, rb_q, clr_q;
  logic [SizeW-1:0]  sa_q, sb_q;
  logic [WgtW-1:0]   ma_q, mb_q;
  logic              oka_q, ok_q;
  logic [gsm_pkg::KW-1:0] k_q;

  logic [VtxW-1:0]  keep, gone;
  logic [WgtW-1:0]  m_sel;
  logic [SizeW-1:0] s_sel;
  logic             lim_ok;

  assign keep   = (ra_q < rb_q) ? ra_q : rb_q;
  assign gone   = (ra_q < rb_q) ? rb_q : ra_q;
  assign m_sel  = cmd_i.eval_b ? mb_q : ma_q;
  assign s_sel  = cmd_i.eval_b ? sb_q : sa_q;
  assign lim_ok = gsm_pkg::within_limit(item_q.edge_weight, m_sel, s_sel, k_q);

  // memory read port follows the walk pointer
  always_ff @(posedge clk_i) begin
    par_rd_q <= par_mem[cur_q];
    sz_rd_q  <= size_mem[cur_q];
    mx_rd_q  <= max_mem[cur_q];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_wr) begin
      par_mem[clr_q]  <= clr_q;
      size_mem[clr_q] <= SizeW'(1);
      max_mem[clr_q]  <= '0;
    end else if (cmd_i.wr_merge) begin
      par_mem[gone]   <= keep;
      size_mem[keep]  <= sa_q + sb_q;
      max_mem[keep]   <= item_q.edge_weight;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q       <= '0;
      k_q         <= gsm_pkg::KReset;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clr_step) clr_q <= clr_q + VtxW'(1);
      if (cfg_we_i)       k_q   <= cfg_wdata_i;
      if (cmd_i.load_out) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      item_q <= in_data_i;
      cur_q  <= in_data_i.vertex_a;
    end else if (cmd_i.step) begin
      cur_q  <= par_rd_q;
    end else if (cmd_i.sel_b) begin
      cur_q  <= item_q.vertex_b;
    end
    if (cmd_i.cap_a) begin
      ra_q <= cur_q;
      sa_q <= sz_rd_q;
      ma_q <= mx_rd_q;
    end
    if (cmd_i.cap_b) begin
      rb_q <= cur_q;
      sb_q <= sz_rd_q;
      mb_q <= mx_rd_q;
    end
    if (cmd_i.load_item)   ok_q  <= 1'b0;
    else if (cmd_i.eval_b) ok_q  <= oka_q && (ra_q != rb_q) && lim_ok;
    if (cmd_i.eval_a)      oka_q <= lim_ok;
    if (cmd_i.load_out) begin
      out_q.joined     <= ok_q;
      out_q.root_label <= ok_q ? keep : ra_q;
    end
  end

  assign status_o.clr_last = (clr_q == '1);
  assign status_o.is_root  = (par_rd_q == cur_q);
  assign status_o.is_query = (item_q.command == gsm_pkg::CmdQuery);
  assign status_o.merge_ok = ok_q;
  assign status_o.out_free = !out_valid_q || out_ready_i;

  assign out_data_o  = out_q;
  assign out_valid_o = out_valid_q;

endmodule

// File: hw/rtl/gsm_ctrl.sv
// Controller: clearing pass, root walks, merge test sequencing and result hand-off
module gsm_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  gsm_pkg::gsm_status_t status_i,
  output gsm_pkg::gsm_cmd_t    cmd_o
);

  gsm_pkg::gsm_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= gsm_pkg::StClear;
    else         state_q <= state_d;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      gsm_pkg::StClear: if (status_i.clr_last) state_d = gsm_pkg::StIdle;
      gsm_pkg::StIdle:  if (in_valid_i) state_d = gsm_pkg::StARd;
      gsm_pkg::StARd:   state_d = gsm_pkg::StAChk;
      gsm_pkg::StAChk: begin
        if (!status_i.is_root)      state_d = gsm_pkg::StARd;
        else if (status_i.is_query) state_d = gsm_pkg::StDone;
        else                        state_d = gsm_pkg::StBRd;
      end
      gsm_pkg::StBRd:   state_d = gsm_pkg::StBChk;
      gsm_pkg::StBChk:  state_d = status_i.is_root ? gsm_pkg::StEvalA : gsm_pkg::StBRd;
      gsm_pkg::StEvalA: state_d = gsm_pkg::StEvalB;
      gsm_pkg::StEvalB: state_d = gsm_pkg::StDone;
      gsm_pkg::StDone:  if (status_i.out_free) state_d = gsm_pkg::StIdle;
      default:          state_d = gsm_pkg::StClear;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      gsm_pkg::StClear: begin
        cmd_o.clr_wr   = 1'b1;
        cmd_o.clr_step = 1'b1;
      end
      gsm_pkg::StIdle: begin
        in_ready_o      = 1'b1;
        cmd_o.load_item = in_valid_i;
      end
      gsm_pkg::StAChk: begin
        cmd_o.cap_a = status_i.is_root;
        cmd_o.step  = !status_i.is_root;
        cmd_o.sel_b = status_i.is_root && !status_i.is_query;
      end
      gsm_pkg::StBChk: begin
        cmd_o.cap_b = status_i.is_root;
        cmd_o.step  = !status_i.is_root;
      end
      gsm_pkg::StEvalA: cmd_o.eval_a = 1'b1;
      gsm_pkg::StEvalB: cmd_o.eval_b = 1'b1;
      gsm_pkg::StDone: begin
        cmd_o.load_out = status_i.out_free;
        cmd_o.wr_merge = status_i.out_free && status_i.merge_ok;
      end
      default: ;
    endcase
  end

endmodule

// File: hw/rtl/graph_segmentation_merge_unit.sv
// Top level of the graph segmentation merge unit
//
// Input channel in_valid_i/in_ready_o carries one item: an edge (two vertices
// and an 8.8 weight, fed in ascending weight order) or a label query.
// Output channel out_valid_o/out_ready_i returns one item per input item:
// the joined flag and the root of vertex_a after the step.
// cfg_we_i/cfg_wdata_i writes the 12.8 merge constant k at once.
// Walk: each vertex on a parent chain passes a state for the registered
// memory read and then a state for the root check. One item is in flight
// at a time, set by the single read port of the union-find memories.
// Reset: a clearing pass rewrites every vertex as its own root with size 1
// and internal maximum 0; in_ready_o stays low meanwhile.
// Stall: the result sits in an output register; if it is still held when
// the next result is done, the engine waits in its final state.
module graph_segmentation_merge_unit (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [gsm_pkg::KW-1:0] cfg_wdata_i,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  gsm_pkg::gsm_in_t       in_data_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output gsm_pkg::gsm_out_t      out_data_o
);

  gsm_pkg::gsm_cmd_t    cmd;
  gsm_pkg::gsm_status_t status;

  gsm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  gsm_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (in_data_i),
    .out_data_o  (out_data_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_i       (cmd),
    .status_o    (status)
  );

endmodule

// File: hw/rtl/gsm_checker.sv
// Port-level checker for the graph segmentation merge unit, with its bind
`include "graph_segmentation_merge_unit_defines.svh"

module gsm_checker (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_valid_i,
  input logic                   in_ready_o,
  input logic                   out_valid_o,
  input logic                   out_ready_i,
  input gsm_pkg::gsm_out_t      out_data_o
);

  `GSM_ASSERT(out_hold_a, clk_i, rst_ni, out_valid_o && !out_ready_i |=> out_valid_o, "result dropped while stalled")
  `GSM_ASSERT(out_stable_a, clk_i, rst_ni, out_valid_o && !out_ready_i |=> $stable(out_data_o), "result changed while stalled")
  `GSM_ASSERT_ALWAYS(rst_quiet_a, clk_i, !rst_ni |-> !out_valid_o && !in_ready_o, "active during reset")
  `GSM_ASSERT(one_item_a, clk_i, rst_ni, in_valid_i && in_ready_o |=> !in_ready_o, "second item taken while busy")
  `GSM_ASSERT(clear_a, clk_i, rst_ni, !$past(rst_ni) |-> !in_ready_o, "ready before clearing pass")

endmodule

bind graph_segmentation_merge_unit gsm_checker u_gsm_checker (.*);

// File: tb/graph_segmentation_merge_unit_tb.sv
// Self-checking testbench for the graph segmentation merge unit
module graph_segmentation_merge_unit_tb;

  localparam int unsigned CycleLimit = 20000000;
  localparam int unsigned PhaseItems = 220;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b1;
  logic                   cfg_we = 1'b0;
  logic [gsm_pkg::KW-1:0] cfg_wdata = '0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  gsm_pkg::gsm_in_t       in_data = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  gsm_pkg::gsm_out_t      out_data;

  graph_segmentation_merge_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  always #2 clk_i = ~clk_i;

  // shadow union-find store
  int unsigned    link_of [gsm_pkg::MaxVertices];
  int unsigned    comp_size [gsm_pkg::MaxVertices];
  int unsigned    comp_max [gsm_pkg::MaxVertices];
  int unsigned    k_val;

  gsm_pkg::gsm_in_t  edge_q[$];
  gsm_pkg::gsm_out_t label_q[$];
  int unsigned    mismatches = 0;
  int unsigned    stall_pct = 0;
  int unsigned    gap_left = 0;
  int unsigned    burst_left = 1;
  int unsigned    cycles = 0;

  function automatic int unsigned root_of(int unsigned v);
    int unsigned steps;
    int unsigned p;
    steps = 0;
    while (steps < gsm_pkg::MaxVertices) begin
      p = link_of[v];
      if (p == v || p >= gsm_pkg::MaxVertices) break;
      v = p;
      steps++;
    end
    return v;
  endfunction

  function automatic int unsigned merge_bound(int unsigned r);
    int unsigned s;
    s = (comp_size[r] == 0) ? 1 : comp_size[r];
    return comp_max[r] + k_val / s;
  endfunction

  function automatic gsm_pkg::gsm_out_t merge_step(gsm_pkg::gsm_in_t it);
    gsm_pkg::gsm_out_t res;
    int unsigned ra;
    int unsigned rb;
    int unsigned keep;
    int unsigned gone;
    res = '0;
    if (it.command == gsm_pkg::CmdEdge) begin
      ra = root_of(it.vertex_a);
      rb = root_of(it.vertex_b);
      if (ra != rb && it.edge_weight <= merge_bound(ra) &&
          it.edge_weight <= merge_bound(rb)) begin
        keep = (ra < rb) ? ra : rb;
        gone = (ra < rb) ? rb : ra;
        comp_size[keep] = comp_size[ra] + comp_size[rb];
        comp_max[keep]  = it.edge_weight;
        link_of[gone]   = keep;
        res.joined      = 1'b1;
      end
    end
    res.root_label = gsm_pkg::VtxW'(root_of(it.vertex_a));
    return res;
  endfunction

  // driver: bursts of items with random gaps
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) label_q = {label_q, merge_step(in_data)};
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (edge_q.size() > 0) begin
          in_data  <= edge_q.pop_front();
          in_valid <= 1'b1;
          burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 20);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor and receiver stall pattern
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (label_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected item: %0d/%0d",
                                         out_data.joined, out_data.root_label);
        end else begin
          gsm_pkg::gsm_out_t exp_res;
          exp_res = label_q.pop_front();
          if (exp_res.joined !== out_data.joined ||
              exp_res.root_label !== out_data.root_label) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: joined exp %0d got %0d, root exp %0d got %0d",
                       exp_res.joined, out_data.joined,
                       exp_res.root_label, out_data.root_label);
          end
        end
      end
      out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic write_k(input int unsigned val);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= gsm_pkg::KW'(val);
    k_val = val;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
  endtask

  task automatic drain();
    wait (edge_q.size() == 0 && !in_valid && label_q.size() == 0);
    repeat (40) @(posedge clk_i);
  endtask

  function automatic gsm_pkg::gsm_in_t mk(logic cmd, int unsigned a, int unsigned b,
                                          int unsigned w);
    gsm_pkg::gsm_in_t it;
    it.command     = cmd;
    it.vertex_a    = gsm_pkg::VtxW'(a);
    it.vertex_b    = gsm_pkg::VtxW'(b);
    it.edge_weight = gsm_pkg::WgtW'(w);
    return it;
  endfunction

  function automatic void add_item(gsm_pkg::gsm_in_t it);
    edge_q = {edge_q, it};
  endfunction

  // random phase: ascending-weight edges and queries over a local vertex window, some noise
  task automatic fill_phase(input int unsigned n, input int unsigned wstep);
    int unsigned base;
    int unsigned span;
    int unsigned w;
    int unsigned a;
    int unsigned b;
    int unsigned pick;
    span = $urandom_range(16, 160);
    base = $urandom_range(0, gsm_pkg::MaxVertices - span);
    w    = (wstep == 0) ? 0 : $urandom_range(0, 64);
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      a = base + $urandom_range(0, span - 1);
      b = base + $urandom_range(0, span - 1);
      if (pick < 25) begin
        add_item(mk(gsm_pkg::CmdQuery, a, $urandom_range(0, gsm_pkg::MaxVertices - 1),
                    $urandom_range(0, 65535)));
      end else if (pick < 35) begin
        // noise: anywhere, any weight
        add_item(mk(1'($urandom_range(0, 1)),
                    $urandom_range(0, gsm_pkg::MaxVertices - 1),
                    $urandom_range(0, gsm_pkg::MaxVertices - 1),
                    $urandom_range(0, 65535)));
      end else begin
        add_item(mk(gsm_pkg::CmdEdge, a, b, w));
        if (w + wstep < 65536) w = w + $urandom_range(0, wstep);
      end
    end
  endtask

  initial begin
    int unsigned kv;
    for (int i = 0; i < gsm_pkg::MaxVertices; i++) begin
      link_of[i]   = i;
      comp_size[i] = 1;
      comp_max[i]  = 0;
    end
    k_val = gsm_pkg::KReset;
    #1 rst_ni = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed items at the reset value of k
    add_item(mk(gsm_pkg::CmdEdge, 0, 1, 0));
    add_item(mk(gsm_pkg::CmdEdge, 1, 0, 5));          // same component
    add_item(mk(gsm_pkg::CmdEdge, 4095, 4094, 65535)); // above bound
    add_item(mk(gsm_pkg::CmdEdge, 4095, 4094, 100));
    add_item(mk(gsm_pkg::CmdQuery, 4095, 0, 0));
    add_item(mk(gsm_pkg::CmdQuery, 4094, 4095, 65535));
    add_item(mk(gsm_pkg::CmdEdge, 2, 3, 200));
    add_item(mk(gsm_pkg::CmdEdge, 3, 1, 300));
    add_item(mk(gsm_pkg::CmdEdge, 4094, 2, 25900));    // size 2 halves the slack, size 4 quarters it
    add_item(mk(gsm_pkg::CmdEdge, 4094, 2, 25700));
    add_item(mk(gsm_pkg::CmdQuery, 4095, 0, 0));
    add_item(mk(gsm_pkg::CmdQuery, 3, 0, 0));
    add_item(mk(gsm_pkg::CmdEdge, 2048, 2048, 0));     // self edge
    add_item(mk(gsm_pkg::CmdEdge, 1365, 2730, 51200)); // exactly at bound
    add_item(mk(gsm_pkg::CmdEdge, 1366, 2731, 51201));
    add_item(mk(gsm_pkg::CmdQuery, 2730, 0, 0));
    drain();

    write_k(0);
    add_item(mk(gsm_pkg::CmdEdge, 10, 11, 0));
    add_item(mk(gsm_pkg::CmdEdge, 12, 13, 1));
    add_item(mk(gsm_pkg::CmdEdge, 10, 4095, 0));
    add_item(mk(gsm_pkg::CmdQuery, 13, 0, 0));
    fill_phase(PhaseItems / 2, 0);
    drain();

    write_k((1 << gsm_pkg::KW) - 1);
    stall_pct = 60;
    fill_phase(PhaseItems, 600);
    drain();

    for (int p = 0; p < 5; p++) begin
      kv = (p == 4) ? gsm_pkg::KReset : $urandom_range(0, (1 << gsm_pkg::KW) - 1);
      if (p == 1) kv = $urandom_range(0, 4096);
      write_k(kv);
      stall_pct = (p % 2 == 0) ? 0 : $urandom_range(10, 80);
      fill_phase(PhaseItems, $urandom_range(1, 400));
      drain();
    end

    if (mismatches == 0 && label_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
